// ===== rtl/variable_partition_allocator_defines.svh =====
// Assertion macros used by the allocator top level.
`ifndef VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define VPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/vpa_pkg.sv =====
// Package with sizes, segment types and codes of the partition allocator.
`default_nettype none
package vpa_pkg;
    localparam int MAX_SEGMENTS = 32;
    localparam int ADDR_BITS    = 16;
    localparam int ID_BITS      = 16;
    localparam int LEN_W        = ADDR_BITS + 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int STAT_W       = 32;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [LEN_W-1:0]     len;
        logic [ID_BITS-1:0]   owner;
    } seg_t;

    typedef struct packed {
        seg_t c0;
        seg_t c1;
        seg_t c2;
    } taps_t;

    localparam logic [LEN_W-1:0] SPACE = LEN_W'(64'd1 << ADDR_BITS);
    localparam seg_t RESET_SEG = '{start: '0, len: SPACE, owner: '0};

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_BAD   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BAD      = 3'd4;

    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_BASE   = 2'd1;
    localparam logic [1:0] CFG_LENGTH = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/variable_partition_allocator.sv =====
// Top level of the partition allocator: control sequencer around the cell ring.
//
//   channel | direction | signals
//   in      | request   | in_valid, in_ready, opcode, owner_id, request_size
//   out     | result    | out_valid, out_ready, status ... free_total
//   cfg     | write     | cfg_we, cfg_index, cfg_wdata
//
// A result is registered once its word has passed the scan, decide, edit and done states.
// The next word is taken only when the sequencer is back in idle, so words do not overlap.
// The cost is two full rotations of the cell ring, one to search and one to edit.
// Reset leaves a single hole over the default region; no clearing pass is needed.
// A result that is not taken holds the sequencer before the next word starts.
`default_nettype none
`include "variable_partition_allocator_defines.svh"
module variable_partition_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [vpa_pkg::ID_BITS-1:0]   owner_id,
    input  logic [vpa_pkg::LEN_W-1:0]     request_size,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [vpa_pkg::ADDR_BITS-1:0] placed_start,
    output logic [vpa_pkg::CNT_W-1:0]     search_count,
    output logic [vpa_pkg::STAT_W-1:0]    placed_total,
    output logic [vpa_pkg::STAT_W-1:0]    search_total,
    output logic [vpa_pkg::CNT_W-1:0]     hole_count,
    output logic [vpa_pkg::LEN_W-1:0]     free_total,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [vpa_pkg::LEN_W-1:0]     cfg_wdata
);
    import vpa_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_EDIT, S_DONE} state_t;
    typedef enum logic [1:0] {M_NONE, M_ALLOC, M_FREE, M_CLEAR} mode_t;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_SEGMENTS - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_SEGMENTS);

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic [CNT_W-1:0] t_reg, t_next;
    logic [1:0] op_reg, op_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [LEN_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] nused_reg, nused_next;
    logic init_reg, init_next;
    logic found_reg, found_next;
    logic [IDX_W-1:0] pick_reg, pick_next;
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic left_reg, left_next, right_reg, right_next;
    logic prevz_reg, prevz_next;
    logic split_reg, split_next;
    seg_t carry_reg, carry_next;
    logic [CNT_W-1:0] holes_reg, holes_next;
    logic [LEN_W-1:0] fsum_reg, fsum_next;
    logic [ADDR_BITS-1:0] pstart_reg, pstart_next;
    logic [2:0] st_reg, st_next;
    logic [STAT_W-1:0] acnt_reg, acnt_next, ssum_reg, ssum_next;
    logic [1:0] pol_reg, pol_next;
    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [LEN_W-1:0] rlen_reg, rlen_next;
    logic out_valid_reg, out_valid_next;
    logic [2:0] o_status_reg, o_status_next;
    logic [ADDR_BITS-1:0] o_start_reg, o_start_next;
    logic [CNT_W-1:0] o_scnt_reg, o_scnt_next;
    logic [STAT_W-1:0] o_ptot_reg, o_ptot_next, o_stot_reg, o_stot_next;
    logic [CNT_W-1:0] o_holes_reg, o_holes_next;
    logic [LEN_W-1:0] o_free_reg, o_free_next;

    taps_t taps;
    seg_t head, tail, eo, clr_seg;
    logic shift, hit, cand, bad;
    logic [CNT_W-1:0] pick_ext, pick_p1, pick_m1;
    logic [LEN_W-1:0] room, sum2, sum3;
    logic [STAT_W:0] acnt_sum, ssum_sum;

    vpa_chain u_chain (
        .clk   (clk),
        .shift (shift),
        .tail  (tail),
        .taps  (taps)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign shift    = (state_reg == S_SCAN) || (state_reg == S_EDIT);
    assign head     = (init_reg && t_reg == '0) ? RESET_SEG : taps.c0;
    assign tail     = (state_reg == S_EDIT) ? eo : head;
    assign hit      = t_reg < used_reg;
    assign cand     = (head.owner == '0) && (head.len >= size_reg);
    assign pick_ext = CNT_W'(pick_reg);
    assign pick_p1  = pick_ext + CNT_W'(1);
    assign pick_m1  = pick_ext - CNT_W'(1);
    assign sum2     = taps.c0.len + taps.c1.len;
    assign sum3     = sum2 + taps.c2.len;
    assign room     = SPACE - LEN_W'(base_reg);
    assign bad      = (op_reg == OP_BAD) || (op_reg != OP_CLEAR && id_reg == '0)
                    || (op_reg == OP_ALLOC && size_reg == '0);
    assign acnt_sum = {1'b0, acnt_reg} + (STAT_W+1)'(1);
    assign ssum_sum = {1'b0, ssum_reg} + (STAT_W+1)'(pick_p1);

    always_comb
    begin
        clr_seg       = '{start: base_reg, len: (rlen_reg > room) ? room : rlen_reg,
                          owner: '0};
        eo            = taps.c0;
        unique case (mode_reg)
            M_ALLOC:
            begin
                if (t_reg == pick_ext)
                    eo = '{start: taps.c0.start, len: size_reg, owner: id_reg};
                else if (split_reg && t_reg == pick_p1)
                    eo = '{start: carry_reg.start + size_reg[ADDR_BITS-1:0],
                           len: carry_reg.len - size_reg, owner: '0};
                else if (split_reg && t_reg > pick_p1)
                    eo = carry_reg;
            end
            M_FREE:
            begin
                case ({left_reg, right_reg})
                    2'b00:
                    begin
                        if (t_reg == pick_ext)
                            eo.owner = '0;
                    end
                    2'b10:
                    begin
                        if (t_reg == pick_m1)
                            eo = '{start: taps.c0.start, len: sum2, owner: '0};
                        else if (t_reg >= pick_ext)
                            eo = taps.c1;
                    end
                    2'b01:
                    begin
                        if (t_reg == pick_ext)
                            eo = '{start: taps.c0.start, len: sum2, owner: '0};
                        else if (t_reg > pick_ext)
                            eo = taps.c1;
                    end
                    default:
                    begin
                        if (t_reg == pick_m1)
                            eo = '{start: taps.c0.start, len: sum3, owner: '0};
                        else if (t_reg >= pick_ext)
                            eo = taps.c2;
                    end
                endcase
            end
            M_CLEAR:
            begin
                if (t_reg == '0)
                    eo = clr_seg;
            end
            default:
            begin
                eo = taps.c0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        t_next         = t_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        size_next      = size_reg;
        used_next      = used_reg;
        nused_next     = nused_reg;
        init_next      = init_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        plen_next      = plen_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        prevz_next     = prevz_reg;
        split_next     = split_reg;
        carry_next     = carry_reg;
        holes_next     = holes_reg;
        fsum_next      = fsum_reg;
        pstart_next    = pstart_reg;
        st_next        = st_reg;
        acnt_next      = acnt_reg;
        ssum_next      = ssum_reg;
        pol_next       = pol_reg;
        base_next      = base_reg;
        rlen_next      = rlen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        o_status_next  = o_status_reg;
        o_start_next   = o_start_reg;
        o_scnt_next    = o_scnt_reg;
        o_ptot_next    = o_ptot_reg;
        o_stot_next    = o_stot_reg;
        o_holes_next   = o_holes_reg;
        o_free_next    = o_free_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY: pol_next  = cfg_wdata[1:0];
                CFG_BASE:   base_next = cfg_wdata[ADDR_BITS-1:0];
                CFG_LENGTH: rlen_next = cfg_wdata;
                default:    ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    id_next    = owner_id;
                    size_next  = request_size;
                    t_next     = '0;
                    found_next = 1'b0;
                    left_next  = 1'b0;
                    right_next = 1'b0;
                    prevz_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    if (op_reg == OP_ALLOC && cand && (!found_reg
                        || (pol_reg == POL_BEST && head.len < plen_reg)
                        || (pol_reg == POL_WORST && head.len > plen_reg)))
                    begin
                        found_next = 1'b1;
                        pick_next  = t_reg[IDX_W-1:0];
                        plen_next  = head.len;
                    end
                    if (op_reg == OP_FREE && !found_reg && head.owner == id_reg)
                    begin
                        found_next = 1'b1;
                        pick_next  = t_reg[IDX_W-1:0];
                        left_next  = (t_reg != '0) && prevz_reg;
                        right_next = (t_reg + CNT_W'(1) < used_reg) && (taps.c1.owner == '0);
                    end
                end
                prevz_next = (head.owner == '0);
                t_next     = t_reg + CNT_W'(1);
                if (t_reg == LAST)
                begin
                    init_next  = 1'b0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                t_next      = '0;
                mode_next   = M_NONE;
                split_next  = 1'b0;
                nused_next  = used_reg;
                holes_next  = '0;
                fsum_next   = '0;
                pstart_next = '0;
                st_next     = ST_OK;
                if (bad)
                    st_next = ST_BAD;
                else if (op_reg == OP_CLEAR)
                begin
                    mode_next  = M_CLEAR;
                    nused_next = CNT_W'(1);
                end
                else if (op_reg == OP_ALLOC)
                begin
                    if (!found_reg)
                        st_next = ST_NOFIT;
                    else if (plen_reg != size_reg && used_reg >= FULL)
                        st_next = ST_FULL;
                    else
                    begin
                        mode_next  = M_ALLOC;
                        split_next = (plen_reg != size_reg);
                        nused_next = used_reg + CNT_W'(plen_reg != size_reg);
                    end
                end
                else if (!found_reg)
                    st_next = ST_NOTFOUND;
                else
                begin
                    mode_next  = M_FREE;
                    nused_next = used_reg - CNT_W'(left_reg) - CNT_W'(right_reg);
                end
                state_next = S_EDIT;
            end
            S_EDIT:
            begin
                carry_next = taps.c0;
                if (mode_reg == M_ALLOC && t_reg == pick_ext)
                    pstart_next = taps.c0.start;
                if (t_reg < nused_reg && eo.owner == '0)
                begin
                    holes_next = holes_reg + CNT_W'(1);
                    fsum_next  = fsum_reg + eo.len;
                end
                t_next = t_reg + CNT_W'(1);
                if (t_reg == LAST)
                begin
                    used_next = nused_reg;
                    if (mode_reg == M_ALLOC)
                    begin
                        acnt_next = acnt_sum[STAT_W] ? '1 : acnt_sum[STAT_W-1:0];
                        ssum_next = ssum_sum[STAT_W] ? '1 : ssum_sum[STAT_W-1:0];
                    end
                    else if (mode_reg == M_CLEAR)
                    begin
                        acnt_next = '0;
                        ssum_next = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = st_reg;
                    o_start_next   = (mode_reg == M_ALLOC) ? pstart_reg : '0;
                    o_scnt_next    = (mode_reg == M_ALLOC) ? pick_p1 : '0;
                    o_ptot_next    = acnt_reg;
                    o_stot_next    = ssum_reg;
                    o_holes_next   = holes_reg;
                    o_free_next    = fsum_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_NONE;
            t_reg         <= '0;
            used_reg      <= CNT_W'(1);
            init_reg      <= 1'b1;
            acnt_reg      <= '0;
            ssum_reg      <= '0;
            pol_reg       <= '0;
            base_reg      <= '0;
            rlen_reg      <= SPACE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            t_reg         <= t_next;
            used_reg      <= used_next;
            init_reg      <= init_next;
            acnt_reg      <= acnt_next;
            ssum_reg      <= ssum_next;
            pol_reg       <= pol_next;
            base_reg      <= base_next;
            rlen_reg      <= rlen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        size_reg     <= size_next;
        nused_reg    <= nused_next;
        found_reg    <= found_next;
        pick_reg     <= pick_next;
        plen_reg     <= plen_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        prevz_reg    <= prevz_next;
        split_reg    <= split_next;
        carry_reg    <= carry_next;
        holes_reg    <= holes_next;
        fsum_reg     <= fsum_next;
        pstart_reg   <= pstart_next;
        st_reg       <= st_next;
        o_status_reg <= o_status_next;
        o_start_reg  <= o_start_next;
        o_scnt_reg   <= o_scnt_next;
        o_ptot_reg   <= o_ptot_next;
        o_stot_reg   <= o_stot_next;
        o_holes_reg  <= o_holes_next;
        o_free_reg   <= o_free_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign placed_start = o_start_reg;
    assign search_count = o_scnt_reg;
    assign placed_total = o_ptot_reg;
    assign search_total = o_stot_reg;
    assign hole_count   = o_holes_reg;
    assign free_total   = o_free_reg;

    `VPA_ASSERT_NOW(a_used_range, 1'b1, (used_reg >= CNT_W'(1)) && (used_reg <= FULL))
    `VPA_ASSERT_NEXT(a_start_scan, in_valid && in_ready, (state_reg == S_SCAN) && (t_reg == '0))
    `VPA_ASSERT_NEXT(a_decide_edit, state_reg == S_DECIDE, (state_reg == S_EDIT) && (t_reg == '0))
endmodule
`default_nettype wire

// ===== rtl/vpa_cell.sv =====
// One table cell: holds a segment and takes its neighbor's segment on shift.
`default_nettype none
module vpa_cell (
    input  logic          clk,
    input  logic          shift,
    input  vpa_pkg::seg_t seg_in,
    output vpa_pkg::seg_t seg_out
);
    import vpa_pkg::*;

    seg_t seg_reg;
    seg_t seg_next;

    assign seg_next = shift ? seg_in : seg_reg;

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

    assign seg_out = seg_reg;
endmodule
`default_nettype wire

// ===== rtl/vpa_chain.sv =====
// Ring of segment cells that rotates toward the head by one cell per shift.
`default_nettype none
module vpa_chain (
    input  logic           clk,
    input  logic           shift,
    input  vpa_pkg::seg_t  tail,
    output vpa_pkg::taps_t taps
);
    import vpa_pkg::*;

    seg_t link [MAX_SEGMENTS+1];

    assign link[MAX_SEGMENTS] = tail;

    for (genvar i = 0; i < MAX_SEGMENTS; i++)
    begin : g_cell
        vpa_cell u_cell (
            .clk     (clk),
            .shift   (shift),
            .seg_in  (link[i+1]),
            .seg_out (link[i])
        );
    end

    assign taps.c0 = link[0];
    assign taps.c1 = link[1];
    assign taps.c2 = link[2];
endmodule
`default_nettype wire
